>>> rtl/core/gda_pkg.sv
// gda_pkg: shared constants, field widths, command/status structs and the
// month length function for the gregorian date add/diff block
// no dependencies
`default_nettype none

package gda_pkg;

   // field widths
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int DAYS_W  = 22;
   localparam int STAT_W  = 2;
   localparam int CENT_W  = 8;   // century of a 14-bit year, up to 163
   localparam int YY_W    = 7;   // year within century, 0..99

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 48;

   localparam int COUNT_BITS_DEF = 22;

   // year / 100 as multiply by reciprocal, exact for any 14-bit year
   localparam int RECIP_W    = 13;
   localparam int RECIP_SH   = 19;
   localparam int PROD_W     = YEAR_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

   localparam logic [6:0] YEARS_PER_CENT = 7'd100;
   localparam logic [CENT_W-1:0] LAST_CENT = 8'd99;
   localparam logic [YY_W-1:0]   LAST_YY   = 7'd99;
   localparam logic [MONTH_W-1:0] JAN = 4'd1;
   localparam logic [MONTH_W-1:0] FEB = 4'd2;
   localparam logic [MONTH_W-1:0] DEC = 4'd12;
   localparam logic [DAY_W-1:0]   FIRST_DAY = 5'd1;
   localparam logic [DAY_W-1:0]   LAST_DEC_DAY = 5'd31;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BAD_DATE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

   // action codes
   localparam logic ACT_ADD  = 1'b0;
   localparam logic ACT_DIFF = 1'b1;

   typedef struct packed {
      logic load;    // take request fields
      logic cent;    // register century of both years
      logic split;   // register year within century, set up both dates
      logic check;   // validate, order dates
      logic step;    // advance working date one day
      logic close;   // stepping finished, settle status
      logic emit;    // move result to output register
   } gda_cmd_type;

   typedef struct packed {
      logic bad;       // an input date is invalid
      logic done;      // stepping finished
      logic out_free;  // output register can take a result
   } gda_stat_type;

   function automatic logic [DAY_W-1:0] days_in_month(
      input logic [CENT_W-1:0]  cent,
      input logic [YY_W-1:0]    yy,
      input logic [MONTH_W-1:0] month
   );
      logic leap;
      logic [DAY_W-1:0] n;
      begin
         // leap when yy%4==0 and (yy!=0 or century%4==0)
         leap = (yy[1:0] == 2'd0) && ((yy != '0) || (cent[1:0] == 2'd0));
         unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
            FEB:                                        n = leap ? 5'd29 : 5'd28;
            default:                                    n = 5'd31;
         endcase
         return n;
      end
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/gda_datapath.sv
// gda_datapath: request registers, year split, date check, day stepper,
// counters and output register
// depends on gda_pkg, driven by gda_ctrl commands
`default_nettype none

module gda_datapath
   import gda_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   output logic      [STAT_W-1:0]     rsp_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire gda_cmd_type           cmd,
   output gda_stat_type               stat
);

   localparam int EXT_W = (COUNT_BITS > DAYS_W) ? COUNT_BITS : DAYS_W;
   localparam int KEY_W = CENT_W + YY_W + MONTH_W + DAY_W;

   // raw request fields
   logic                  mode_ff, mode_in;
   logic [YEAR_W-1:0]     ya_ff, ya_in, yb_ff, yb_in;
   logic [MONTH_W-1:0]    ma_ff, ma_in, mb_ff, mb_in;
   logic [DAY_W-1:0]      da_ff, da_in, db_ff, db_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   // split years
   logic [CENT_W-1:0]     ca_ff, ca_in, cb_ff, cb_in;
   logic [YY_W-1:0]       yya_ff, yya_in, yyb_ff, yyb_in;
   // working and target date
   logic [CENT_W-1:0]     wc_ff, wc_in, tc_ff, tc_in;
   logic [YY_W-1:0]       wy_ff, wy_in, ty_ff, ty_in;
   logic [MONTH_W-1:0]    wm_ff, wm_in, tm_ff, tm_in;
   logic [DAY_W-1:0]      wd_ff, wd_in, td_ff, td_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [STAT_W-1:0]     res_ff, res_in;
   // output register
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic [STAT_W-1:0]     out_stat_ff, out_stat_in;
   logic                  valid_ff, valid_in;

   logic [EXT_W-1:0]  add_ext, cnt_ext;
   logic [PROD_W-1:0] prod_a, prod_b;
   logic [14:0]       hund_a, hund_b, year_w;
   logic              valid_a, valid_b, a_first, bad;
   logic [KEY_W-1:0]  key_a, key_b, key_w, key_t;
   logic [DAY_W-1:0]  dim_w;
   logic              at_max, rem_zero, done;
   logic [YEAR_W-1:0] yo;
   logic [MONTH_W-1:0] mo;
   logic [DAY_W-1:0]  dout;
   logic [DAYS_W-1:0] diff;

   always_comb begin
      add_ext = EXT_W'(req_tdata[67:46]);
      cnt_ext = EXT_W'(cnt_ff);
      prod_a  = PROD_W'(ya_ff) * PROD_W'(RECIP_100);
      prod_b  = PROD_W'(yb_ff) * PROD_W'(RECIP_100);
      hund_a  = 15'(ca_ff) * 15'(YEARS_PER_CENT);
      hund_b  = 15'(cb_ff) * 15'(YEARS_PER_CENT);
      valid_a = (ca_ff <= LAST_CENT) && (ma_ff >= JAN) && (ma_ff <= DEC) &&
                (da_ff >= FIRST_DAY) && (da_ff <= days_in_month(ca_ff, yya_ff, ma_ff));
      valid_b = (cb_ff <= LAST_CENT) && (mb_ff >= JAN) && (mb_ff <= DEC) &&
                (db_ff >= FIRST_DAY) && (db_ff <= days_in_month(cb_ff, yyb_ff, mb_ff));
      bad     = !valid_a || ((mode_ff == ACT_DIFF) && !valid_b);
      key_a   = {ca_ff, yya_ff, ma_ff, da_ff};
      key_b   = {cb_ff, yyb_ff, mb_ff, db_ff};
      a_first = key_a <= key_b;
      key_w   = {wc_ff, wy_ff, wm_ff, wd_ff};
      key_t   = {tc_ff, ty_ff, tm_ff, td_ff};
      dim_w   = days_in_month(wc_ff, wy_ff, wm_ff);
      at_max  = (wc_ff == LAST_CENT) && (wy_ff == LAST_YY) && (wm_ff == DEC) &&
                (wd_ff == LAST_DEC_DAY);
      rem_zero = (rem_ff == '0);
      done    = (mode_ff == ACT_DIFF) ? (key_w == key_t) : (rem_zero || at_max);
      year_w  = 15'(wc_ff) * 15'(YEARS_PER_CENT) + 15'(wy_ff);
   end

   assign stat.bad      = bad;
   assign stat.done     = done;
   assign stat.out_free = !valid_ff || rsp_tready;

   // result fields by mode and status
   always_comb begin
      yo   = '0;
      mo   = '0;
      dout = '0;
      diff = '0;
      if (mode_ff == ACT_ADD) begin
         if (res_ff == STAT_OK) begin
            yo   = year_w[YEAR_W-1:0];
            mo   = wm_ff;
            dout = wd_ff;
         end else begin
            yo   = ya_ff;
            mo   = ma_ff;
            dout = da_ff;
         end
      end else if (res_ff == STAT_OK) begin
         diff = cnt_ext[DAYS_W-1:0];
      end
   end

   always_comb begin
      mode_in = mode_ff;
      ya_in = ya_ff; ma_in = ma_ff; da_in = da_ff;
      yb_in = yb_ff; mb_in = mb_ff; db_in = db_ff;
      rem_in = rem_ff;
      ca_in = ca_ff; cb_in = cb_ff;
      yya_in = yya_ff; yyb_in = yyb_ff;
      wc_in = wc_ff; wy_in = wy_ff; wm_in = wm_ff; wd_in = wd_ff;
      tc_in = tc_ff; ty_in = ty_ff; tm_in = tm_ff; td_in = td_ff;
      cnt_in = cnt_ff;
      res_in = res_ff;
      out_data_in = out_data_ff;
      out_stat_in = out_stat_ff;
      valid_in = valid_ff && !rsp_tready;

      if (cmd.load) begin
         mode_in = req_tuser;
         ya_in = req_tdata[13:0];  ma_in = req_tdata[17:14]; da_in = req_tdata[22:18];
         yb_in = req_tdata[36:23]; mb_in = req_tdata[40:37]; db_in = req_tdata[45:41];
         rem_in = add_ext[COUNT_BITS-1:0];
      end
      if (cmd.cent) begin
         ca_in = prod_a[PROD_W-1:RECIP_SH];
         cb_in = prod_b[PROD_W-1:RECIP_SH];
      end
      if (cmd.split) begin
         yya_in = YY_W'(15'(ya_ff) - hund_a);
         yyb_in = YY_W'(15'(yb_ff) - hund_b);
      end
      if (cmd.check) begin
         cnt_in = '0;
         res_in = bad ? STAT_BAD_DATE : STAT_OK;
         if ((mode_ff == ACT_ADD) || a_first) begin
            wc_in = ca_ff; wy_in = yya_ff; wm_in = ma_ff; wd_in = da_ff;
            tc_in = cb_ff; ty_in = yyb_ff; tm_in = mb_ff; td_in = db_ff;
         end else begin
            wc_in = cb_ff; wy_in = yyb_ff; wm_in = mb_ff; wd_in = db_ff;
            tc_in = ca_ff; ty_in = yya_ff; tm_in = ma_ff; td_in = da_ff;
         end
      end
      if (cmd.step) begin
         // one calendar day forward
         if (wd_ff == dim_w) begin
            wd_in = FIRST_DAY;
            if (wm_ff == DEC) begin
               wm_in = JAN;
               if (wy_ff == LAST_YY) begin
                  wy_in = '0;
                  wc_in = wc_ff + 1'b1;
               end else begin
                  wy_in = wy_ff + 1'b1;
               end
            end else begin
               wm_in = wm_ff + 1'b1;
            end
         end else begin
            wd_in = wd_ff + 1'b1;
         end
         rem_in = rem_zero ? rem_ff : rem_ff - 1'b1;
         cnt_in = (&cnt_ff) ? cnt_ff : cnt_ff + 1'b1;
      end
      if (cmd.close && (mode_ff == ACT_ADD) && !rem_zero) begin
         res_in = STAT_OVERFLOW;
      end
      if (cmd.emit) begin
         out_data_in = {3'b000, diff, dout, mo, yo};
         out_stat_in = res_ff;
         valid_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      ya_ff <= ya_in; ma_ff <= ma_in; da_ff <= da_in;
      yb_ff <= yb_in; mb_ff <= mb_in; db_ff <= db_in;
      rem_ff <= rem_in;
      ca_ff <= ca_in; cb_ff <= cb_in;
      yya_ff <= yya_in; yyb_ff <= yyb_in;
      wc_ff <= wc_in; wy_ff <= wy_in; wm_ff <= wm_in; wd_ff <= wd_in;
      tc_ff <= tc_in; ty_ff <= ty_in; tm_ff <= tm_in; td_ff <= td_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
      out_data_ff <= out_data_in;
      out_stat_ff <= out_stat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_stat_ff;
   assign rsp_tvalid = valid_ff;

   // difference stepping never passes the later date
   a_diff_order: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && (mode_ff == ACT_DIFF)) |-> (key_w < key_t))
      else $error("working date passed target date");

   // add stepping only with days left and below the last date
   a_add_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && (mode_ff == ACT_ADD)) |-> (!rem_zero && !at_max))
      else $error("add stepping past count or last date");

   // a result handed over shows up valid next cycle
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> valid_ff)
      else $error("emitted result not valid");

   // bad date status never comes from the stepper
   a_close_status: assert property (@(posedge clock) disable iff (reset)
      cmd.close |=> (res_ff != STAT_BAD_DATE))
      else $error("bad date status after stepping");

endmodule

`default_nettype wire

>>> rtl/core/gda_ctrl.sv
// gda_ctrl: state machine sequencing load, year split, check, day stepping
// and result hand-over
// depends on gda_pkg, drives gda_datapath
`default_nettype none

module gda_ctrl
   import gda_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire gda_stat_type stat,
   output gda_cmd_type       cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CENT   = 3'd1;
   localparam logic [2:0] ST_SPLIT  = 3'd2;
   localparam logic [2:0] ST_CHECK  = 3'd3;
   localparam logic [2:0] ST_RUN    = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE) && !reset;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CENT;
            end
         end
         ST_CENT: begin
            cmd.cent = 1'b1;
            state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            cmd.split = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = stat.bad ? ST_FINISH : ST_RUN;
         end
         ST_RUN: begin
            if (stat.done) begin
               cmd.close = 1'b1;
               state_in  = ST_FINISH;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // at most one datapath command per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command");

   // a loaded item always goes through the year split next
   a_load_seq: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.cent ##1 cmd.split ##1 cmd.check)
      else $error("load not followed by split and check");

endmodule

`default_nettype wire

>>> rtl/core/gregorian_date_add_and_diff.sv
// gregorian_date_add_and_diff: top level, gregorian date add and difference
// depends on gda_pkg, gda_ctrl, gda_datapath
//
//  channel  dir  handshake             payload
//  req      in   req_tvalid/tready     tdata: dates and day count, tuser: action
//  rsp      out  rsp_tvalid/tready     tdata: result date and day count, tuser: status
//
//  an item is taken while idle and passes the states cent, split, check, run and
//  finish; in run the single day-increment unit advances the working date one day
//  per cycle through the day count in add mode (or the days up to 9999-12-31 on
//  overflow) and the day difference in difference mode; an invalid date skips run;
//  finish waits for the output register to be free, then hands the result over and
//  returns to idle, where the next item can be taken
//  one item at a time; req_tready is high only while idle and out of reset
//  a finished result waits in the output register, the next item is taken meanwhile
//  reset is synchronous and clears control state only
`default_nettype none

module gregorian_date_add_and_diff
   import gda_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // year_a[13:0] month_a[17:14] day_a[22:18] year_b[36:23] month_b[40:37]
   // day_b[45:41] days_to_add[67:46], zero fill above
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // action[0]
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // year_out[13:0] month_out[17:14] day_out[22:18] day_difference[44:23],
   // zero fill above
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic      [STAT_W-1:0]     rsp_tuser
);

   gda_cmd_type  cmd;
   gda_stat_type stat;

   // sequencer
   gda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // date registers, day stepper and output register
   gda_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

`default_nettype wire

>>> sim/gregorian_date_add_and_diff_tb.sv
// gregorian_date_add_and_diff_tb: self-checking bench for the gregorian date add/diff block
// drives requests on the req stream and checks every rsp item against a calendar predictor
// depends on gda_pkg and gregorian_date_add_and_diff
`default_nettype none

module gregorian_date_add_and_diff_tb
   import gda_pkg::*;
();

   localparam int CLK_HALF    = 10;
   localparam int RESET_CYC   = 12;
   localparam int RANDOM_REQS = 600;
   localparam int IDLE_PCT    = 38;
   localparam int DRAIN_CYC   = 20;
   localparam int CYCLE_LIMIT = 6_000_000;
   localparam int MAX_COUNT   = (1 << DAYS_W) - 1;
   localparam int LAST_YEAR   = 9999;

   // one request as the block sees it
   typedef struct packed {
      logic               action;
      logic [YEAR_W-1:0]  year_a;
      logic [MONTH_W-1:0] month_a;
      logic [DAY_W-1:0]   day_a;
      logic [YEAR_W-1:0]  year_b;
      logic [MONTH_W-1:0] month_b;
      logic [DAY_W-1:0]   day_b;
      logic [DAYS_W-1:0]  days_to_add;
   } date_req_type;

   // one result item
   typedef struct packed {
      logic [YEAR_W-1:0]  year_out;
      logic [MONTH_W-1:0] month_out;
      logic [DAY_W-1:0]   day_out;
      logic [DAYS_W-1:0]  day_difference;
      logic [STAT_W-1:0]  status;
   } date_rsp_type;

   // calendar predictor plus queue of results still owed by the block
   class date_scoreboard;
      date_rsp_type pending_results[$];
      int           errors = 0;

      function bit leap_year(int unsigned y);
         return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      endfunction

      function int unsigned month_days(int unsigned y, int unsigned m);
         case (m)
            4, 6, 9, 11: return 30;
            2:           return leap_year(y) ? 29 : 28;
            default:     return 31;
         endcase
      endfunction

      function bit date_ok(int unsigned y, int unsigned m, int unsigned d);
         if (y > LAST_YEAR || m < 1 || m > 12 || d < 1) return 1'b0;
         return d <= month_days(y, m);
      endfunction

      // days from 0000-01-01 to january 1st of year y
      function longint unsigned year_origin(longint unsigned y);
         longint unsigned p;
         if (y == 0) return 0;
         p = y - 1;
         return 365 * y + p / 4 - p / 100 + p / 400 + 1;
      endfunction

      function longint unsigned day_number(int unsigned y, int unsigned m, int unsigned d);
         longint unsigned n;
         n = year_origin(y);
         for (int unsigned k = 1; k < m; k++) n += month_days(y, k);
         return n + d - 1;
      endfunction

      function void calendar_date(longint unsigned n, output int unsigned y,
                                  output int unsigned m, output int unsigned d);
         longint unsigned yy;
         yy = n / 366;
         while (year_origin(yy + 1) <= n) yy++;
         n -= year_origin(yy);
         m = 1;
         while (m < 12 && n >= month_days(32'(yy), m)) begin
            n -= month_days(32'(yy), m);
            m++;
         end
         y = 32'(yy);
         d = 32'(n + 1);
      endfunction

      function date_rsp_type predict(date_req_type r);
         date_rsp_type    e;
         longint unsigned sa, sb, span;
         int unsigned     y, m, d;
         e = '0;
         if (r.action == ACT_ADD) begin
            // unchanged first date unless the add goes through
            e.year_out  = r.year_a;
            e.month_out = r.month_a;
            e.day_out   = r.day_a;
            if (!date_ok(r.year_a, r.month_a, r.day_a)) begin
               e.status = STAT_BAD_DATE;
            end else begin
               sa = day_number(r.year_a, r.month_a, r.day_a) + r.days_to_add;
               if (sa > day_number(LAST_YEAR, 12, 31)) begin
                  e.status = STAT_OVERFLOW;
               end else begin
                  calendar_date(sa, y, m, d);
                  e.year_out  = YEAR_W'(y);
                  e.month_out = MONTH_W'(m);
                  e.day_out   = DAY_W'(d);
                  e.status    = STAT_OK;
               end
            end
         end else begin
            if (!date_ok(r.year_a, r.month_a, r.day_a) ||
                !date_ok(r.year_b, r.month_b, r.day_b)) begin
               e.status = STAT_BAD_DATE;
            end else begin
               sa   = day_number(r.year_a, r.month_a, r.day_a);
               sb   = day_number(r.year_b, r.month_b, r.day_b);
               span = (sa >= sb) ? sa - sb : sb - sa;
               // saturate at the counter width
               if (span > MAX_COUNT) span = MAX_COUNT;
               e.day_difference = DAYS_W'(span);
               e.status         = STAT_OK;
            end
         end
         return e;
      endfunction

      function void note_request(date_req_type r);
         pending_results.push_back(predict(r));
      endfunction

      function void compare(string field, longint unsigned want, longint unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
         end
      endfunction

      function void check_result(date_rsp_type got);
         date_rsp_type want;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: result with no request pending, expected none actual %p",
                     $time, got);
            return;
         end
         want = pending_results.pop_front();
         compare("year_out", want.year_out, got.year_out);
         compare("month_out", want.month_out, got.month_out);
         compare("day_out", want.day_out, got.day_out);
         compare("day_difference", want.day_difference, got.day_difference);
         compare("status", want.status, got.status);
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = ACT_ADD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0]     rsp_tuser;

   date_scoreboard sb = new();
   bit             steady = 1'b0;   // both sides run with no idling while set
   int             cycle_count = 0;

   gregorian_date_add_and_diff dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // result side: random backpressure, every accepted item goes to the scoreboard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result('{year_out:       rsp_tdata[13:0],
                              month_out:      rsp_tdata[17:14],
                              day_out:        rsp_tdata[22:18],
                              day_difference: rsp_tdata[44:23],
                              status:         rsp_tuser});
         end
      end
   end

   // watchdog against a hung block
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   function automatic date_req_type mk(logic act, int ya, int ma, int da,
                                       int yb, int mb, int db, int cnt);
      date_req_type r;
      r.action      = act;
      r.year_a      = YEAR_W'(ya);
      r.month_a     = MONTH_W'(ma);
      r.day_a       = DAY_W'(da);
      r.year_b      = YEAR_W'(yb);
      r.month_b     = MONTH_W'(mb);
      r.day_b       = DAY_W'(db);
      r.days_to_add = DAYS_W'(cnt);
      return r;
   endfunction

   // random valid date with the year in [lo, hi]
   task automatic pick_date(int lo, int hi, output int y, output int m, output int d);
      y = $urandom_range(hi, lo);
      m = $urandom_range(12, 1);
      d = $urandom_range(sb.month_days(y, m), 1);
   endtask

   // mostly well-formed requests with short day spans to keep each item brief; the
   // rest are bad dates and overflowing adds
   task automatic random_request(output date_req_type r);
      int roll, ya, ma, da, yb, mb, db, cnt;
      roll = $urandom_range(99, 0);
      yb   = $urandom_range((1 << YEAR_W) - 1, 0);
      mb   = $urandom_range((1 << MONTH_W) - 1, 0);
      db   = $urandom_range((1 << DAY_W) - 1, 0);
      cnt  = $urandom_range(MAX_COUNT, 0);
      if (roll < 40) begin
         pick_date(0, LAST_YEAR, ya, ma, da);
         r = mk(ACT_ADD, ya, ma, da, yb, mb, db, $urandom_range(1500, 0));
      end else if (roll < 50) begin
         // near the top of the calendar, large counts overflow quickly
         pick_date(LAST_YEAR - 3, LAST_YEAR, ya, ma, da);
         if ($urandom_range(1, 0)) cnt = $urandom_range(1500, 0);
         r = mk(ACT_ADD, ya, ma, da, yb, mb, db, cnt);
      end else if (roll < 80) begin
         pick_date(0, LAST_YEAR, ya, ma, da);
         pick_date((ya < 3) ? 0 : ya - 3, (ya > LAST_YEAR - 3) ? LAST_YEAR : ya + 3,
                   yb, mb, db);
         r = mk(ACT_DIFF, ya, ma, da, yb, mb, db, cnt);
      end else begin
         // bad first date across the full field widths
         ya = $urandom_range((1 << YEAR_W) - 1, 0);
         ma = $urandom_range((1 << MONTH_W) - 1, 0);
         da = $urandom_range((1 << DAY_W) - 1, 0);
         if (sb.date_ok(ya, ma, da)) ma = $urandom_range(15, 13);
         if (roll < 90) begin
            r = mk(ACT_ADD, ya, ma, da, yb, mb, db, cnt);
         end else begin
            // second date valid half the time, and either slot may hold the bad one
            if ($urandom_range(1, 0)) pick_date(0, LAST_YEAR, yb, mb, db);
            if ($urandom_range(1, 0))
               r = mk(ACT_DIFF, ya, ma, da, yb, mb, db, cnt);
            else
               r = mk(ACT_DIFF, yb, mb, db, ya, ma, da, cnt);
         end
      end
   endtask

   // present one item with random idle cycles ahead of it, return once accepted
   task automatic send_request(date_req_type r);
      while (!steady && $urandom_range(99, 0) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.action;
      req_tdata  <= {{(REQ_DATA_W - 68){1'b0}}, r.days_to_add, r.day_b, r.month_b,
                     r.year_b, r.day_a, r.month_a, r.year_a};
      do @(posedge clock); while (!req_tready);
      sb.note_request(r);
   endtask

   initial begin
      date_req_type r;
      repeat (RESET_CYC) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: leap rules, year ends, top of range, bad dates, both orders
      send_request(mk(ACT_ADD, 0, 1, 1, 0, 0, 0, 0));
      send_request(mk(ACT_ADD, 0, 2, 28, 0, 0, 0, 1));          // year zero is leap
      send_request(mk(ACT_ADD, 1900, 2, 28, 0, 0, 0, 1));       // century, not leap
      send_request(mk(ACT_ADD, 2000, 2, 28, 0, 0, 0, 1));       // 400-year leap
      send_request(mk(ACT_ADD, 1999, 12, 31, 0, 0, 0, 1));
      send_request(mk(ACT_ADD, 2024, 1, 1, 0, 0, 0, 366));
      send_request(mk(ACT_ADD, 2096, 3, 1, 0, 0, 0, 4000));     // runs over 2100
      send_request(mk(ACT_ADD, 9999, 12, 31, 0, 0, 0, 0));
      send_request(mk(ACT_ADD, 9999, 12, 31, 0, 0, 0, 1));      // one past the end
      send_request(mk(ACT_ADD, 9999, 6, 1, 16383, 15, 31, MAX_COUNT));
      send_request(mk(ACT_ADD, 2023, 0, 10, 0, 0, 0, 5));       // month zero
      send_request(mk(ACT_ADD, 2023, 13, 10, 0, 0, 0, 5));
      send_request(mk(ACT_ADD, 2023, 4, 31, 0, 0, 0, 5));       // day past month end
      send_request(mk(ACT_ADD, 2100, 2, 29, 0, 0, 0, 5));
      send_request(mk(ACT_ADD, 2023, 5, 0, 0, 0, 0, 5));        // day zero
      send_request(mk(ACT_ADD, 10000, 1, 1, 0, 0, 0, 5));      // year past range
      send_request(mk(ACT_ADD, 16383, 15, 31, 16383, 15, 31, MAX_COUNT));
      send_request(mk(ACT_DIFF, 2020, 5, 17, 2020, 5, 17, 0));
      send_request(mk(ACT_DIFF, 2099, 11, 30, 2101, 3, 1, 0));
      send_request(mk(ACT_DIFF, 2101, 3, 1, 2099, 11, 30, 0));
      send_request(mk(ACT_DIFF, 9998, 1, 1, 9999, 12, 31, MAX_COUNT));
      send_request(mk(ACT_DIFF, 0, 1, 1, 0, 12, 31, 0));
      send_request(mk(ACT_DIFF, 2023, 2, 29, 2023, 3, 1, 0));   // bad first date
      send_request(mk(ACT_DIFF, 2023, 3, 1, 16383, 15, 31, 0)); // bad second date

      for (int i = 0; i < RANDOM_REQS; i++) begin
         steady = (i >= 250 && i < 350);
         random_request(r);
         send_request(r);
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      if (sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
